FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clock and held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising edge outside reset
`define PSG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that a condition is followed in the next cycle by another
`define PSG_ASSERT_NEXT(label, ante, cons, msg) \
   `PSG_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: hdl/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared widths, register map, micro-operation codes and control structs
// of the prime sieve generator.
// ----------------------------------------------------------------------------
package psg_pkg;

   localparam int DEFAULT_SIEVE_DEPTH = 65536;

   localparam int LIMIT_W = 17;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;
   localparam int VALUE_W = 16;
   localparam int FIRST_PRIME = 2;

   // bit map rows
   localparam int MAP_ROW_W  = 32;
   localparam int ROW_SEL_W  = 5;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_LIMIT = 1'b0;

   // micro-operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
   localparam logic [OP_W-1:0] OP_START  = 4'd1;
   localparam logic [OP_W-1:0] OP_CLR    = 4'd2;
   localparam logic [OP_W-1:0] OP_RD_CUR = 4'd3;
   localparam logic [OP_W-1:0] OP_SKIP   = 4'd4;
   localparam logic [OP_W-1:0] OP_FOUND  = 4'd5;
   localparam logic [OP_W-1:0] OP_J_INIT = 4'd6;
   localparam logic [OP_W-1:0] OP_RD_J   = 4'd7;
   localparam logic [OP_W-1:0] OP_WR_J   = 4'd8;
   localparam logic [OP_W-1:0] OP_EMIT   = 4'd9;

   typedef struct packed {
      logic            req_fire;
      logic            restart;
      logic            clr_more;
      logic            cur_ge_bound;
      logic            marked;
      logic            sq_ge_bound;
      logic            j_next_lt;
      logic            out_free;
   } stat_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            idle;
   } ctrl_type;

endpackage

FILE: hdl/psg_if.sv
// ----------------------------------------------------------------------------
// psg_if
// Valid/ready channels of the prime sieve generator: request and response.
// ----------------------------------------------------------------------------
interface psg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface psg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [psg_pkg::VALUE_W-1:0]  prime_value;
   logic [psg_pkg::VALUE_W-1:0]  prime_count;
   logic                         exhausted;

   modport source (output valid, output prime_value, output prime_count,
                   output exhausted, input ready);
   modport sink   (input valid, input prime_value, input prime_count,
                   input exhausted, output ready);
endinterface

FILE: hdl/psg_map.sv
// ----------------------------------------------------------------------------
// psg_map
// Composite bit map: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module psg_map #(
   parameter int ROWS   = 2048,
   parameter int ADDR_W = 11
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [psg_pkg::MAP_ROW_W-1:0]  rd_data,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [psg_pkg::MAP_ROW_W-1:0]  wr_data
);
   import psg_pkg::*;

   logic [MAP_ROW_W-1:0] mem [ROWS];
   logic [MAP_ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/psg_seq.sv
// ----------------------------------------------------------------------------
// psg_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module psg_seq (
   input  logic               clock,
   input  logic               reset,
   input  psg_pkg::stat_type  stat,
   output psg_pkg::ctrl_type  ctrl
);
   import psg_pkg::*;

   localparam int STEP_W = 4;
   localparam int COND_W = 4;

   localparam logic [STEP_W-1:0] S_BOOT      = 4'd0;
   localparam logic [STEP_W-1:0] S_BOOT_CLR  = 4'd1;
   localparam logic [STEP_W-1:0] S_IDLE      = 4'd2;
   localparam logic [STEP_W-1:0] S_CHK_RST   = 4'd3;
   localparam logic [STEP_W-1:0] S_START     = 4'd4;
   localparam logic [STEP_W-1:0] S_CLR       = 4'd5;
   localparam logic [STEP_W-1:0] S_SCAN      = 4'd6;
   localparam logic [STEP_W-1:0] S_SKIP      = 4'd7;
   localparam logic [STEP_W-1:0] S_FOUND     = 4'd8;
   localparam logic [STEP_W-1:0] S_SQ_CHK    = 4'd9;
   localparam logic [STEP_W-1:0] S_J_INIT    = 4'd10;
   localparam logic [STEP_W-1:0] S_MARK_RD   = 4'd11;
   localparam logic [STEP_W-1:0] S_MARK_WR   = 4'd12;
   localparam logic [STEP_W-1:0] S_EMIT      = 4'd13;
   localparam logic [STEP_W-1:0] S_EMIT_WAIT = 4'd14;
   localparam logic [STEP_W-1:0] S_SPARE     = 4'd15;

   localparam logic [COND_W-1:0] C_NEVER        = 4'd0;
   localparam logic [COND_W-1:0] C_ALWAYS       = 4'd1;
   localparam logic [COND_W-1:0] C_NO_REQ       = 4'd2;
   localparam logic [COND_W-1:0] C_NO_RESTART   = 4'd3;
   localparam logic [COND_W-1:0] C_CLR_MORE     = 4'd4;
   localparam logic [COND_W-1:0] C_CUR_GE_BOUND = 4'd5;
   localparam logic [COND_W-1:0] C_MARKED       = 4'd6;
   localparam logic [COND_W-1:0] C_SQ_GE_BOUND  = 4'd7;
   localparam logic [COND_W-1:0] C_J_NEXT_LT    = 4'd8;
   localparam logic [COND_W-1:0] C_OUT_FREE     = 4'd9;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
   } uword_type;

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   uword_type         uword;
   logic              taken;

   // control store
   always_comb begin
      case (pc_ff)
         S_BOOT:      uword = '{OP_START,  C_NEVER,        S_BOOT};
         S_BOOT_CLR:  uword = '{OP_CLR,    C_CLR_MORE,     S_BOOT_CLR};
         S_IDLE:      uword = '{OP_NOP,    C_NO_REQ,       S_IDLE};
         S_CHK_RST:   uword = '{OP_NOP,    C_NO_RESTART,   S_SCAN};
         S_START:     uword = '{OP_START,  C_NEVER,        S_START};
         S_CLR:       uword = '{OP_CLR,    C_CLR_MORE,     S_CLR};
         S_SCAN:      uword = '{OP_RD_CUR, C_CUR_GE_BOUND, S_EMIT};
         S_SKIP:      uword = '{OP_SKIP,   C_MARKED,       S_SCAN};
         S_FOUND:     uword = '{OP_FOUND,  C_NEVER,        S_FOUND};
         S_SQ_CHK:    uword = '{OP_NOP,    C_SQ_GE_BOUND,  S_EMIT};
         S_J_INIT:    uword = '{OP_J_INIT, C_NEVER,        S_J_INIT};
         S_MARK_RD:   uword = '{OP_RD_J,   C_NEVER,        S_MARK_RD};
         S_MARK_WR:   uword = '{OP_WR_J,   C_J_NEXT_LT,    S_MARK_RD};
         S_EMIT:      uword = '{OP_EMIT,   C_OUT_FREE,     S_IDLE};
         S_EMIT_WAIT: uword = '{OP_NOP,    C_ALWAYS,       S_EMIT};
         S_SPARE:     uword = '{OP_NOP,    C_ALWAYS,       S_IDLE};
         default:     uword = '{OP_NOP,    C_ALWAYS,       S_IDLE};
      endcase
   end

   always_comb begin
      case (uword.cond)
         C_NEVER:        taken = 1'b0;
         C_ALWAYS:       taken = 1'b1;
         C_NO_REQ:       taken = !stat.req_fire;
         C_NO_RESTART:   taken = !stat.restart;
         C_CLR_MORE:     taken = stat.clr_more;
         C_CUR_GE_BOUND: taken = stat.cur_ge_bound;
         C_MARKED:       taken = stat.marked;
         C_SQ_GE_BOUND:  taken = stat.sq_ge_bound;
         C_J_NEXT_LT:    taken = stat.j_next_lt;
         C_OUT_FREE:     taken = stat.out_free;
         default:        taken = 1'b0;
      endcase
   end

   assign pc_in = taken ? uword.target : pc_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_BOOT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.op   = uword.op;
   assign ctrl.idle = (pc_ff == S_IDLE);

endmodule

FILE: hdl/prime_sieve_generator_unit.sv
// ----------------------------------------------------------------------------
// prime_sieve_generator_unit
// Sieve of Eratosthenes handing out the next prime on each request word.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   req_chan  in         valid/ready          restart
//   rsp_chan  out        valid/ready          prime_value, prime_count, exhausted
//   p*        in         APB write/read       limit at byte address 0
//
// After reset a clearing pass writes ROWS = SIEVE_DEPTH/32 (rounded up) map rows,
// one per cycle; requests wait until it ends.
// A request scans on from the cursor until it runs out or finds a prime; each
// number costs a map read and a test. A prime whose square is below the bound
// marks its multiples before the response: an init step, then a read-modify-write
// per multiple (read port, then write port); a restart first clears the map again.
// A request is taken while the sequencer sits idle; a finished response waits
// in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prime_sieve_generator_unit #(
   parameter int SIEVE_DEPTH = psg_pkg::DEFAULT_SIEVE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [psg_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [psg_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [psg_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   psg_req_if.sink                         req_chan,
   psg_rsp_if.source                       rsp_chan
);
   import psg_pkg::*;

   localparam int VAL_W  = $clog2(SIEVE_DEPTH) + 1;
   localparam int CW     = (VAL_W > LIMIT_W) ? VAL_W : LIMIT_W;
   localparam int SQ_W   = 2 * CW;
   localparam int ROWS   = (SIEVE_DEPTH + MAP_ROW_W - 1) / MAP_ROW_W;
   localparam int RA_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

   // register port
   logic [LIMIT_W-1:0]   limit_ff;
   logic [LIMIT_W-1:0]   limit_in;
   logic                 csr_wr;

   // datapath
   logic [CW-1:0]        cursor_ff, cursor_in;
   logic [CW-1:0]        prime_ff, prime_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic [CW-1:0]        j_ff, j_in;
   logic [VALUE_W-1:0]   count_ff, count_in;
   logic                 exh_ff, exh_in;
   logic [RA_W-1:0]      clr_ff, clr_in;
   logic                 restart_ff, restart_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [VALUE_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_exh_ff, rsp_exh_in;

   logic [CW-1:0]        bound;
   logic [CW:0]          j_sum;
   logic                 req_fire;
   logic                 out_free;
   logic                 marked;
   stat_type             stat;
   ctrl_type             ctrl;

   logic                 map_rd_en;
   logic [RA_W-1:0]      map_rd_addr;
   logic [MAP_ROW_W-1:0] map_rd_data;
   logic                 map_wr_en;
   logic [RA_W-1:0]      map_wr_addr;
   logic [MAP_ROW_W-1:0] map_wr_data;

   // ---------------------------------------------------------------- csr
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign limit_in = (csr_wr && paddr[2] == REG_LIMIT) ? pwdata[LIMIT_W-1:0] : limit_ff;
   assign prdata = (paddr[2] == REG_LIMIT) ? CSR_DATA_W'(limit_ff) : '0;

   // saturate the bound at the map depth
   assign bound = (CW'(limit_ff) < CW'(SIEVE_DEPTH)) ? CW'(limit_ff) : CW'(SIEVE_DEPTH);

   // ---------------------------------------------------------------- status
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign marked   = map_rd_data[cursor_ff[ROW_SEL_W-1:0]];
   assign j_sum    = {1'b0, j_ff} + {1'b0, prime_ff};

   assign stat.req_fire     = req_fire;
   assign stat.restart      = restart_ff;
   assign stat.clr_more     = (clr_ff != RA_W'(ROWS - 1));
   assign stat.cur_ge_bound = (cursor_ff >= bound);
   assign stat.marked       = marked;
   assign stat.sq_ge_bound  = (sq_ff >= SQ_W'(bound));
   assign stat.j_next_lt    = (j_sum < {1'b0, bound});
   assign stat.out_free     = out_free;

   psg_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   assign req_chan.ready = ctrl.idle;

   // ---------------------------------------------------------------- map
   assign map_rd_en   = (ctrl.op == OP_RD_CUR) || (ctrl.op == OP_RD_J);
   assign map_rd_addr = (ctrl.op == OP_RD_J) ? j_ff[ROW_SEL_W +: RA_W]
                                             : cursor_ff[ROW_SEL_W +: RA_W];
   assign map_wr_en   = (ctrl.op == OP_CLR) || (ctrl.op == OP_WR_J);
   assign map_wr_addr = (ctrl.op == OP_CLR) ? clr_ff : j_ff[ROW_SEL_W +: RA_W];
   assign map_wr_data = (ctrl.op == OP_CLR) ? '0
                      : map_rd_data | (MAP_ROW_W'(1) << j_ff[ROW_SEL_W-1:0]);

   psg_map #(
      .ROWS   (ROWS),
      .ADDR_W (RA_W)
   ) u_map (
      .clock   (clock),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data)
   );

   // ---------------------------------------------------------------- datapath
   always_comb begin
      cursor_in    = cursor_ff;
      prime_in     = prime_ff;
      sq_in        = sq_ff;
      j_in         = j_ff;
      count_in     = count_ff;
      exh_in       = exh_ff;
      clr_in       = clr_ff;
      restart_in   = restart_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rsp_exh_in   = rsp_exh_ff;
      if (req_fire) begin
         restart_in = req_chan.restart;
      end
      case (ctrl.op)
         OP_START: begin
            cursor_in = CW'(FIRST_PRIME);
            count_in  = '0;
            clr_in    = '0;
         end
         OP_CLR: begin
            clr_in = clr_ff + 1'b1;
         end
         OP_RD_CUR: begin
            exh_in = (cursor_ff >= bound);
         end
         OP_SKIP: begin
            // step over a composite
            cursor_in = cursor_ff + CW'(marked);
         end
         OP_FOUND: begin
            prime_in  = cursor_ff;
            count_in  = count_ff + 1'b1;
            cursor_in = cursor_ff + 1'b1;
            sq_in     = SQ_W'(cursor_ff) * SQ_W'(cursor_ff);
         end
         OP_J_INIT: begin
            j_in = sq_ff[CW-1:0];
         end
         OP_WR_J: begin
            j_in = j_sum[CW-1:0];
         end
         OP_EMIT: begin
            // load only when the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = exh_ff ? '0 : prime_ff[VALUE_W-1:0];
               rsp_count_in = count_ff;
               rsp_exh_in   = exh_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         restart_ff   <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         restart_ff   <= restart_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff    <= cursor_in;
      prime_ff     <= prime_in;
      sq_ff        <= sq_in;
      j_ff         <= j_in;
      count_ff     <= count_in;
      exh_ff       <= exh_in;
      clr_ff       <= clr_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
      rsp_exh_ff   <= rsp_exh_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.prime_value = rsp_value_ff;
   assign rsp_chan.prime_count = rsp_count_ff;
   assign rsp_chan.exhausted   = rsp_exh_ff;

   // ---------------------------------------------------------------- checks
   `PSG_ASSERT(a_mark_in_range, (ctrl.op == OP_WR_J) |-> (j_ff < bound), "marking past the bound")
   `PSG_ASSERT(a_found_unmarked, (ctrl.op == OP_FOUND) |-> (cursor_ff < bound && !marked), "found a marked number")
   `PSG_ASSERT_NEXT(a_ready_drops, req_fire, !req_chan.ready, "second word taken while busy")
   `PSG_ASSERT_NEXT(a_emit_loads, (ctrl.op == OP_EMIT && out_free), rsp_chan.valid, "response not loaded")

endmodule
